### src/rbws_pkg.sv
// shared constants, types and helper functions for the reset brownian walk stepper
// no dependencies; imported by every module of the block
package rbws_pkg;

  localparam int DIMS      = 2;
  localparam int LANES     = 4;
  localparam int NDIM      = (DIMS < LANES) ? DIMS : LANES;
  localparam int MAX_STEPS = 1048576;

  localparam int DRAW_W  = 16;
  localparam int NORM_W  = 16;
  localparam int THR_W   = 17;
  localparam int SDT_W   = 16;
  localparam int PROD_W  = NORM_W + SDT_W + 1;
  localparam int DISP_W  = PROD_W - 4;
  localparam int POS_W   = 48;
  localparam int CNT_W   = 21;

  localparam int CAP_INT = (MAX_STEPS < (2**CNT_W - 1)) ? MAX_STEPS : (2**CNT_W - 1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP_INT);

  localparam int IN_DATA_W  = DRAW_W + LANES * NORM_W;
  localparam int OUT_RAW_W  = 2 * LANES * POS_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [SDT_W-1:0] SQRT_DT_RESET = SDT_W'(256);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SQRT_DT   = 2'd1
  } cfg_reg_t;

  // scaled step handed from the scale stage to the walk stage
  typedef struct packed {
    logic                         start;
    logic                         hit;
    logic [NDIM-1:0][DISP_W-1:0]  disp;
  } disp_t;

  // one result item
  typedef struct packed {
    logic [CNT_W-1:0]             longest;
    logic [CNT_W-1:0]             resets;
    logic                         hit;
    logic [LANES-1:0][POS_W-1:0]  pos;
    logic [LANES-1:0][POS_W-1:0]  step;
  } res_t;

  function automatic logic [POS_W-1:0] sat_wide(input logic [POS_W:0] v);
    logic [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c < CNT_CAP) ? c + CNT_W'(1) : CNT_CAP;
    return r;
  endfunction

endpackage

### src/rbws_scale.sv
// input register, reset draw compare and gaussian scaling, with a registered output
// depends on rbws_pkg
module rbws_scale import rbws_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start,
  input  logic [DRAW_W-1:0]             draw,
  input  logic [LANES-1:0][NORM_W-1:0]  normal,
  input  logic [THR_W-1:0]              threshold,
  input  logic [SDT_W-1:0]              sqrt_dt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output disp_t                         out_item
);

  logic                          v1;
  logic                          start1;
  logic [DRAW_W-1:0]             draw1;
  logic [LANES-1:0][NORM_W-1:0]  norm1;
  logic                          en1;
  logic                          en2;
  disp_t                         item_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign item_next.start = start1;
  assign item_next.hit   = {1'b0, draw1} < threshold;

  for (genvar k = 0; k < NDIM; k++) begin : g_lane
    logic signed [PROD_W-1:0] prod;
    assign prod = PROD_W'($signed(norm1[k])) * PROD_W'($signed({1'b0, sqrt_dt}));
    // arithmetic drop of four bits rounds toward minus infinity
    assign item_next.disp[k] = prod[PROD_W-1:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      start1 <= start;
      draw1  <= draw;
      norm1  <= normal;
    end
    if (en2 && v1) begin
      out_item <= item_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !in_ready |-> (v1 && out_valid))
    else $error("scale stage stalled with an empty stage");

endmodule

### src/rbws_walk.sv
// walk state (position, reset count, runs) and the result register
// depends on rbws_pkg
module rbws_walk import rbws_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  disp_t  in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   res
);

  logic [POS_W-1:0]  pos [NDIM];
  logic [POS_W-1:0]  pos_next [NDIM];
  logic [CNT_W-1:0]  reset_total;
  logic [CNT_W-1:0]  cur_run;
  logic [CNT_W-1:0]  best_run;
  logic [CNT_W-1:0]  reset_total_next;
  logic [CNT_W-1:0]  cur_run_next;
  logic [CNT_W-1:0]  best_run_next;
  logic              acc;
  res_t              res_next;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < NDIM) begin : g_used
      logic [POS_W-1:0] base;
      logic [POS_W-1:0] dx;
      logic [POS_W:0]   sum;
      assign base = in_item.start ? '0 : pos[k];
      assign dx   = {{(POS_W-DISP_W){in_item.disp[k][DISP_W-1]}}, in_item.disp[k]};
      // a reset step cancels the old position, otherwise it accumulates
      assign sum  = in_item.hit ? ({dx[POS_W-1], dx} - {base[POS_W-1], base})
                                : ({base[POS_W-1], base} + {dx[POS_W-1], dx});
      assign pos_next[k]      = in_item.hit ? dx : sat_wide(sum);
      assign res_next.step[k] = in_item.hit ? sat_wide(sum) : dx;
      assign res_next.pos[k]  = pos_next[k];
    end else begin : g_unused
      assign res_next.step[k] = '0;
      assign res_next.pos[k]  = '0;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] rt_b;
    logic [CNT_W-1:0] cr_b;
    logic [CNT_W-1:0] br_b;
    rt_b = in_item.start ? '0 : reset_total;
    cr_b = in_item.start ? '0 : cur_run;
    br_b = in_item.start ? '0 : best_run;
    reset_total_next = in_item.hit ? inc_sat(rt_b) : rt_b;
    cur_run_next     = in_item.hit ? CNT_W'(1) : inc_sat(cr_b);
    best_run_next    = (cur_run_next > br_b) ? cur_run_next : br_b;
  end

  assign res_next.hit     = in_item.hit;
  assign res_next.resets  = reset_total_next;
  assign res_next.longest = best_run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      reset_total <= '0;
      cur_run     <= '0;
      best_run    <= '0;
      for (int k = 0; k < NDIM; k++) pos[k] <= '0;
    end else begin
      if (acc) begin
        out_valid   <= 1'b1;
        reset_total <= reset_total_next;
        cur_run     <= cur_run_next;
        best_run    <= best_run_next;
        for (int k = 0; k < NDIM; k++) pos[k] <= pos_next[k];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res <= res_next;
  end

  assert property (@(posedge clk) disable iff (rst) best_run >= cur_run)
    else $error("longest run below current run");

  assert property (@(posedge clk) disable iff (rst) (acc && in_item.hit) |=> (cur_run == 1))
    else $error("reset step did not restart the run");

  assert property (@(posedge clk) disable iff (rst)
                   (reset_total <= CNT_CAP) && (cur_run <= CNT_CAP))
    else $error("counter beyond saturation cap");

endmodule

### src/reset_brownian_walk_stepper.sv
// Brownian walk stepper with stochastic resetting. One walk step is taken per clock:
// s_axis transfers are accepted every cycle while the result side keeps up, and each
// step's result passes the input register, the multiply into a registered displacement,
// and the combinational position and counter update into the result register before it
// is presented on m_axis. The one-step-per-clock figure is set by that position
// update, a 49-bit add with saturation that closes on itself each
// cycle. Configuration writes are taken at any time (cfg_ready stays high) and must
// only be issued while no step is in flight.
// depends on rbws_pkg, rbws_scale, rbws_walk
module reset_brownian_walk_stepper import rbws_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // uniform_draw, normal_0, normal_1, normal_2, normal_3
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // start_walk
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // step_0..step_3, pos_0..pos_3, resets_so_far, longest_run, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // reset_hit
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [THR_W-1:0]              threshold;
  logic [SDT_W-1:0]              sqrt_dt;
  logic [LANES-1:0][NORM_W-1:0]  normal;
  logic                          mid_valid;
  logic                          mid_ready;
  disp_t                         mid_item;
  res_t                          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      sqrt_dt   <= SQRT_DT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_THRESHOLD) threshold <= cfg_data[THR_W-1:0];
      if (cfg_index == REG_SQRT_DT)   sqrt_dt   <= cfg_data[SDT_W-1:0];
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_unpack
    assign normal[k] = s_axis_tdata[DRAW_W + k*NORM_W +: NORM_W];
  end

  rbws_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .start     (s_axis_tuser),
    .draw      (s_axis_tdata[DRAW_W-1:0]),
    .normal    (normal),
    .threshold (threshold),
    .sqrt_dt   (sqrt_dt),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  rbws_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_item   (mid_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, res.longest, res.resets,
                         res.pos, res.step};
  assign m_axis_tuser = res.hit;

  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while the result register is empty");

endmodule
